[rtl/core/i2c_rts_pkg.sv]
// ----------------------------------------------------------------------------
// i2c_rts_pkg
// Shared types and constants of the I2C register transaction sequencer.
// ----------------------------------------------------------------------------
package i2c_rts_pkg;

    localparam int TIMEOUT_WIDTH_DEF = 16;
    localparam int CFG_WIDTH         = 16;
    localparam logic [CFG_WIDTH-1:0] CFG_LIMIT_RST = 16'd10000;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int MAX_ACTS = 3;

    typedef enum logic [3:0] {
        OP_PING       = 4'd0,
        OP_WRITE      = 4'd1,
        OP_READ       = 4'd2,
        OP_START_SENT = 4'd3,
        OP_ADDR_ACK   = 4'd4,
        OP_ACK_FAIL   = 4'd5,
        OP_TX_EMPTY   = 4'd6,
        OP_RX_BYTE    = 4'd7,
        OP_TICK       = 4'd8
    } t_op;

    typedef enum logic [3:0] {
        ACT_START    = 4'd0,
        ACT_SEND     = 4'd1,
        ACT_SET_ACK  = 4'd2,
        ACT_CLR_ACK  = 4'd3,
        ACT_CLR_ADDR = 4'd4,
        ACT_CLR_FAIL = 4'd5,
        ACT_STOP     = 4'd6,
        ACT_DELIVER  = 4'd7,
        ACT_FINISH   = 4'd8
    } t_act;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ACK_FAIL = 2'd1,
        ST_TIMEOUT  = 2'd2,
        ST_BAD_LEN  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_PING  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_WAIT_START   = 3'd1,
        PH_WAIT_ADDR    = 3'd2,
        PH_WAIT_TX_REG  = 3'd3,
        PH_WAIT_TX_DATA = 3'd4,
        PH_WAIT_RX      = 3'd5
    } t_phase;

    // Up to three actions from one input word; byte goes with send or
    // deliver, status goes with finished.
    typedef struct packed {
        t_act [MAX_ACTS-1:0] act;
        logic [1:0]          cnt;
        logic [7:0]          data;
        t_status             st;
    } t_bundle;

endpackage

[rtl/core/i2c_rts_if.sv]
// ----------------------------------------------------------------------------
// i2c_rts_if
// Command/event channel and result channel of the sequencer.
// ----------------------------------------------------------------------------
interface i2c_rts_cmd_if;
    logic       valid;
    logic       ready;
    logic [3:0] opcode;
    logic [6:0] device_address;
    logic [7:0] register_index;
    logic [7:0] data_byte;
    logic [7:0] read_length;

    modport source (
        output valid, opcode, device_address, register_index, data_byte, read_length,
        input  ready
    );
    modport sink (
        input  valid, opcode, device_address, register_index, data_byte, read_length,
        output ready
    );
endinterface

interface i2c_rts_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] action;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;

    modport source (
        output valid, action, out_byte, status, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, action, out_byte, status, last_of_run,
        output ready
    );
endinterface

[rtl/core/i2c_rts_front.sv]
// ----------------------------------------------------------------------------
// i2c_rts_front
// Accepts command and event words, tracks the transaction phase and the
// timeout counter, and queues the resulting action bundle.
// ----------------------------------------------------------------------------
module i2c_rts_front #(
    parameter int TIMEOUT_WIDTH = i2c_rts_pkg::TIMEOUT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [i2c_rts_pkg::CFG_WIDTH-1:0] i_cfg_wdata,
    i2c_rts_cmd_if.sink                      i_cmd,
    input  logic                             i_full,
    output logic                             o_push,
    output i2c_rts_pkg::t_bundle             o_bundle
);
    import i2c_rts_pkg::*;

    logic [CFG_WIDTH-1:0]     r_limit;
    t_phase                   r_phase, n_phase;
    t_kind                    r_kind, n_kind;
    logic [6:0]               r_addr, n_addr;
    logic [7:0]               r_reg, n_reg;
    logic [7:0]               r_wbyte, n_wbyte;
    logic [7:0]               r_total, n_total;
    logic [7:0]               r_pos, n_pos;
    logic                     r_rdir, n_rdir;
    logic [TIMEOUT_WIDTH-1:0] r_cnt, n_cnt;

    logic                           w_acc;
    t_op                            w_op;
    logic [TIMEOUT_WIDTH+CFG_WIDTH-1:0] w_lim_ext;
    logic [TIMEOUT_WIDTH-1:0]       w_load;
    logic [TIMEOUT_WIDTH-1:0]       w_dec;
    logic [7:0]                     w_next_pos;
    logic                           w_rx_stop;
    logic                           w_rx_done;
    logic                           w_have;
    t_bundle                        w_bun;

    assign i_cmd.ready = !i_full;
    assign w_acc       = i_cmd.valid && !i_full;
    assign w_op        = t_op'(i_cmd.opcode);
    assign w_lim_ext   = {{TIMEOUT_WIDTH{1'b0}}, r_limit};
    assign w_load      = w_lim_ext[TIMEOUT_WIDTH-1:0];
    assign w_dec       = r_cnt - {{(TIMEOUT_WIDTH-1){1'b0}}, 1'b1};
    assign w_next_pos  = r_pos + 8'd1;
    assign w_rx_stop   = (r_total >= 8'd2) && (r_pos == r_total - 8'd2);
    assign w_rx_done   = (w_next_pos >= r_total);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_addr  = r_addr;
        n_reg   = r_reg;
        n_wbyte = r_wbyte;
        n_total = r_total;
        n_pos   = r_pos;
        n_rdir  = r_rdir;
        n_cnt   = r_cnt;
        if (w_acc) begin
            case (w_op)
                OP_PING, OP_WRITE, OP_READ: begin
                    if (r_phase == PH_IDLE &&
                        !(w_op == OP_READ && i_cmd.read_length == 8'd0)) begin
                        n_kind  = t_kind'(i_cmd.opcode[1:0]);
                        n_addr  = i_cmd.device_address;
                        n_reg   = i_cmd.register_index;
                        n_wbyte = i_cmd.data_byte;
                        n_total = i_cmd.read_length;
                        n_pos   = 8'd0;
                        n_rdir  = 1'b0;
                        n_phase = PH_WAIT_START;
                        n_cnt   = w_load;
                    end
                end
                OP_START_SENT: begin
                    if (r_phase == PH_WAIT_START) begin
                        n_phase = PH_WAIT_ADDR;
                        n_cnt   = w_load;
                    end
                end
                OP_ADDR_ACK: begin
                    if (r_phase == PH_WAIT_ADDR) begin
                        if (r_kind == KIND_PING) begin
                            n_phase = PH_IDLE;
                            n_rdir  = 1'b0;
                        end else if (!r_rdir) begin
                            n_phase = PH_WAIT_TX_REG;
                            n_cnt   = w_load;
                        end else begin
                            n_pos   = 8'd0;
                            n_phase = PH_WAIT_RX;
                            n_cnt   = w_load;
                        end
                    end
                end
                OP_ACK_FAIL: begin
                    if (r_phase == PH_WAIT_ADDR || r_phase == PH_WAIT_TX_REG ||
                        r_phase == PH_WAIT_TX_DATA) begin
                        n_phase = PH_IDLE;
                        n_rdir  = 1'b0;
                    end
                end
                OP_TX_EMPTY: begin
                    if (r_phase == PH_WAIT_TX_REG) begin
                        if (r_kind == KIND_WRITE) begin
                            n_phase = PH_WAIT_TX_DATA;
                        end else begin
                            n_rdir  = 1'b1;
                            n_phase = PH_WAIT_START;
                        end
                        n_cnt = w_load;
                    end else if (r_phase == PH_WAIT_TX_DATA) begin
                        n_phase = PH_IDLE;
                        n_rdir  = 1'b0;
                    end
                end
                OP_RX_BYTE: begin
                    if (r_phase == PH_WAIT_RX) begin
                        if (w_rx_done) begin
                            n_phase = PH_IDLE;
                            n_rdir  = 1'b0;
                        end else begin
                            n_cnt = w_load;
                        end
                        n_pos = w_next_pos;
                    end
                end
                OP_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        n_cnt = w_dec;
                        if (w_dec == '0) begin
                            n_phase = PH_IDLE;
                            n_rdir  = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // action bundle
    always_comb begin
        w_have = 1'b0;
        w_bun  = '0;
        case (w_op)
            OP_PING, OP_WRITE, OP_READ: begin
                if (r_phase == PH_IDLE) begin
                    w_have = 1'b1;
                    w_bun.cnt = 2'd1;
                    if (w_op == OP_READ && i_cmd.read_length == 8'd0) begin
                        w_bun.act[0] = ACT_FINISH;
                        w_bun.st     = ST_BAD_LEN;
                    end else begin
                        w_bun.act[0] = ACT_START;
                    end
                end
            end
            OP_START_SENT: begin
                if (r_phase == PH_WAIT_START) begin
                    w_have       = 1'b1;
                    w_bun.cnt    = 2'd1;
                    w_bun.act[0] = ACT_SEND;
                    w_bun.data   = {r_addr, r_rdir};
                end
            end
            OP_ADDR_ACK: begin
                if (r_phase == PH_WAIT_ADDR) begin
                    w_have = 1'b1;
                    if (r_kind == KIND_PING) begin
                        w_bun.cnt    = 2'd3;
                        w_bun.act[0] = ACT_CLR_ADDR;
                        w_bun.act[1] = ACT_STOP;
                        w_bun.act[2] = ACT_FINISH;
                    end else if (!r_rdir) begin
                        w_bun.cnt    = 2'd2;
                        w_bun.act[0] = ACT_CLR_ADDR;
                        w_bun.act[1] = ACT_SEND;
                        w_bun.data   = r_reg;
                    end else if (r_total == 8'd1) begin
                        w_bun.cnt    = 2'd3;
                        w_bun.act[0] = ACT_CLR_ACK;
                        w_bun.act[1] = ACT_CLR_ADDR;
                        w_bun.act[2] = ACT_STOP;
                    end else begin
                        w_bun.cnt    = 2'd2;
                        w_bun.act[0] = ACT_SET_ACK;
                        w_bun.act[1] = ACT_CLR_ADDR;
                    end
                end
            end
            OP_ACK_FAIL: begin
                if (r_phase == PH_WAIT_ADDR || r_phase == PH_WAIT_TX_REG ||
                    r_phase == PH_WAIT_TX_DATA) begin
                    w_have       = 1'b1;
                    w_bun.cnt    = 2'd3;
                    w_bun.act[0] = ACT_CLR_FAIL;
                    w_bun.act[1] = ACT_STOP;
                    w_bun.act[2] = ACT_FINISH;
                    w_bun.st     = ST_ACK_FAIL;
                end
            end
            OP_TX_EMPTY: begin
                if (r_phase == PH_WAIT_TX_REG) begin
                    w_have    = 1'b1;
                    w_bun.cnt = 2'd1;
                    if (r_kind == KIND_WRITE) begin
                        w_bun.act[0] = ACT_SEND;
                        w_bun.data   = r_wbyte;
                    end else begin
                        w_bun.act[0] = ACT_START;
                    end
                end else if (r_phase == PH_WAIT_TX_DATA) begin
                    w_have       = 1'b1;
                    w_bun.cnt    = 2'd2;
                    w_bun.act[0] = ACT_STOP;
                    w_bun.act[1] = ACT_FINISH;
                end
            end
            OP_RX_BYTE: begin
                if (r_phase == PH_WAIT_RX) begin
                    w_have     = 1'b1;
                    w_bun.data = i_cmd.data_byte;
                    if (w_rx_stop) begin
                        w_bun.cnt    = 2'd3;
                        w_bun.act[0] = ACT_CLR_ACK;
                        w_bun.act[1] = ACT_STOP;
                        w_bun.act[2] = ACT_DELIVER;
                    end else if (w_rx_done) begin
                        w_bun.cnt    = 2'd2;
                        w_bun.act[0] = ACT_DELIVER;
                        w_bun.act[1] = ACT_FINISH;
                    end else begin
                        w_bun.cnt    = 2'd1;
                        w_bun.act[0] = ACT_DELIVER;
                    end
                end
            end
            OP_TICK: begin
                if (r_phase != PH_IDLE && w_dec == '0) begin
                    w_have   = 1'b1;
                    w_bun.st = ST_TIMEOUT;
                    if (r_kind == KIND_PING) begin
                        w_bun.cnt    = 2'd2;
                        w_bun.act[0] = ACT_STOP;
                        w_bun.act[1] = ACT_FINISH;
                    end else begin
                        w_bun.cnt    = 2'd1;
                        w_bun.act[0] = ACT_FINISH;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_push   = w_acc && w_have;
    assign o_bundle = w_bun;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= CFG_LIMIT_RST;
            r_phase <= PH_IDLE;
            r_kind  <= KIND_PING;
            r_addr  <= '0;
            r_reg   <= '0;
            r_wbyte <= '0;
            r_total <= '0;
            r_pos   <= '0;
            r_rdir  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_addr  <= n_addr;
            r_reg   <= n_reg;
            r_wbyte <= n_wbyte;
            r_total <= n_total;
            r_pos   <= n_pos;
            r_rdir  <= n_rdir;
            r_cnt   <= n_cnt;
        end
    end

    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_cmd.valid && i_cmd.ready))
        else $error("bundle pushed without an accepted word");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_bundle.cnt != 2'd0 && o_bundle.cnt != 2'd3 ||
                    o_bundle.cnt == 2'd3))
        else $error("empty bundle pushed");

    a_idle_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> !r_rdir)
        else $error("read direction set while idle");

    a_rx_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT_RX) |-> (r_kind == KIND_READ && r_rdir))
        else $error("receive phase outside read direction");

endmodule

[rtl/core/i2c_rts_queue.sv]
// ----------------------------------------------------------------------------
// i2c_rts_queue
// Short bundle queue between the classifying front and the output back.
// ----------------------------------------------------------------------------
module i2c_rts_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  i2c_rts_pkg::t_bundle i_bundle,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output i2c_rts_pkg::t_bundle o_head
);
    import i2c_rts_pkg::*;

    t_bundle              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr;
    logic [Q_PTR_W-1:0]   r_rptr;
    logic [Q_PTR_W:0]     r_count;
    logic                 w_do_push;
    logic                 w_do_pop;

    assign o_full    = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_mem[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + (Q_PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (Q_PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_PTR_W+1)'(Q_DEPTH))
        else $error("queue count out of range");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !i_push) |=> (r_count == $past(r_count) - (Q_PTR_W+1)'(1)))
        else $error("pop did not drain an entry");

endmodule

[rtl/core/i2c_rts_back.sv]
// ----------------------------------------------------------------------------
// i2c_rts_back
// Walks the head bundle one action per word onto the result channel.
// ----------------------------------------------------------------------------
module i2c_rts_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  i2c_rts_pkg::t_bundle i_head,
    output logic                 o_pop,
    i2c_rts_res_if.source        o_res
);
    import i2c_rts_pkg::*;

    logic [1:0] r_slot;
    t_act       w_act;
    logic       w_last;
    logic       w_take;

    assign w_act  = i_head.act[r_slot];
    assign w_last = (r_slot == i_head.cnt - 2'd1);
    assign w_take = o_res.valid && o_res.ready;

    assign o_res.valid       = !i_empty;
    assign o_res.action      = w_act;
    assign o_res.out_byte    = (w_act == ACT_SEND || w_act == ACT_DELIVER) ? i_head.data : 8'd0;
    assign o_res.status      = (w_act == ACT_FINISH) ? i_head.st : ST_OK;
    assign o_res.last_of_run = w_last;
    assign o_pop             = w_take && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_slot <= '0;
            end else begin
                r_slot <= r_slot + 2'd1;
            end
        end
    end

    a_slot_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_slot < i_head.cnt))
        else $error("slot beyond bundle length");

    a_slot_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (r_slot == $past(r_slot)))
        else $error("slot moved while stalled");

    a_slot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> (r_slot == 2'd0))
        else $error("slot not cleared with empty queue");

endmodule

[rtl/core/i2c_register_transaction_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer
// I2C master register transaction sequencer: ping, register write and
// register read, driven by command and peripheral event words.
//
//   channel   dir  handshake      word
//   i_cmd     in   valid/ready    opcode, address, register, data, length
//   o_res     out  valid/ready    action, out_byte, status, last_of_run
//   i_cfg_*   in   write enable   timeout limit (16 bit)
//
// One input word is taken per cycle while the two-entry bundle queue has
// room; each word leaves up to three result words, sent one per cycle
// while o_res is ready. Output stalls reach the input only once the
// queue is full.
// Reset is synchronous and active low; no clearing pass.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer #(
    parameter int TIMEOUT_WIDTH = i2c_rts_pkg::TIMEOUT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [i2c_rts_pkg::CFG_WIDTH-1:0] i_cfg_wdata,
    i2c_rts_cmd_if.sink                       i_cmd,
    i2c_rts_res_if.source                     o_res
);
    import i2c_rts_pkg::*;

    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    t_bundle w_in_bun;
    t_bundle w_head;

    i2c_rts_front #(
        .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_bundle    (w_in_bun)
    );

    i2c_rts_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_in_bun),
        .i_pop    (w_pop),
        .o_full   (w_full),
        .o_empty  (w_empty),
        .o_head   (w_head)
    );

    i2c_rts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule
